// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the route stepper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GGRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A property that must hold whenever its enabling condition is true.
`define GGRS_ASSERT_IF(lbl, en, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |-> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/ggrs_pkg.sv
// ----------------------------------------------------------------------------
// ggrs_pkg
// Types, codes and constants shared by the grid route stepper modules.
// ----------------------------------------------------------------------------
package ggrs_pkg;

    localparam int GRID_COLS_DEF = 16;
    localparam int GRID_ROWS_DEF = 10;
    localparam int NCELLS_DEF    = (GRID_COLS_DEF + 1) * (GRID_ROWS_DEF + 1);

    // Field widths of the transaction payloads.
    localparam int REQ_W      = 2;
    localparam int HALF_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int DIR_W      = 2;
    localparam int LDIR_W     = 3;
    localparam int POSX_W     = 5;
    localparam int POSY_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CELL_W     = 2;
    localparam int BND_W      = 8;
    localparam int COST_W     = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MOVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GOAL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STUCK = 2'd3;

    // Move directions; the wide form also carries "no move yet".
    localparam logic [LDIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [LDIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [LDIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [LDIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [LDIR_W-1:0] DIR_NONE  = 3'd4;

    // Cell states held in the map memory.
    localparam logic [CELL_W-1:0] CELL_FREE    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_VISITED = 2'd1;
    localparam logic [CELL_W-1:0] CELL_BLOCKED = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y  = 2'd3;

    localparam logic [POSX_W-1:0] START_X_RST = 5'd1;
    localparam logic [POSY_W-1:0] START_Y_RST = 4'd4;
    localparam logic [POSX_W-1:0] GOAL_X_RST  = 5'd12;
    localparam logic [POSY_W-1:0] GOAL_Y_RST  = 4'd6;

    // Costs keep the ordering of the full-range costs: distances stay far below.
    localparam logic [COST_W-1:0] COST_BLOCKED = 8'hFF;
    localparam logic [COST_W-1:0] COST_VISITED = 8'hFE;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [HALF_W-1:0] center_x_half;
        logic [HALF_W-1:0] center_y_half;
        logic [HALF_W-1:0] width_half;
        logic [HALF_W-1:0] length_half;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIR_W-1:0]    direction;
        logic [POSX_W-1:0]   pos_x;
        logic [POSY_W-1:0]   pos_y;
    } t_res;

    typedef logic signed [BND_W-1:0] t_bnd;

    // Rectangle outline bounds: raw edges and edges clipped to the grid.
    typedef struct packed {
        t_bnd xl;
        t_bnd xh;
        t_bnd yl;
        t_bnd yh;
        t_bnd xlo;
        t_bnd xhi;
        t_bnd ylo;
        t_bnd yhi;
        logic empty;
    } t_rect_bnd;

endpackage

// File: rtl/core/ggrs_ram.sv
// ----------------------------------------------------------------------------
// ggrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ggrs_ram #(
    parameter int WIDTH = ggrs_pkg::CELL_W,
    parameter int DEPTH = ggrs_pkg::NCELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ggrs_rect_bounds.sv
// ----------------------------------------------------------------------------
// ggrs_rect_bounds
// Turns a half-tile rectangle into outline cell bounds, raw and clipped.
// ----------------------------------------------------------------------------
module ggrs_rect_bounds #(
    parameter int GRID_COLS = ggrs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = ggrs_pkg::GRID_ROWS_DEF
) (
    input  ggrs_pkg::t_req      i_req,
    output ggrs_pkg::t_rect_bnd o_bnd
);

    import ggrs_pkg::*;

    localparam int A_W = HALF_W + 3;
    localparam logic signed [A_W-1:0] ROUND_UP = 3;
    localparam t_bnd COL_LIM = t_bnd'(GRID_COLS);
    localparam t_bnd ROW_LIM = t_bnd'(GRID_ROWS);
    localparam t_bnd ZERO    = '0;

    // Edges in quarter-tile units are divided by four with rounding up or down.
    function automatic t_bnd ceil_q(input logic signed [A_W-1:0] a);
        return t_bnd'((a + ROUND_UP) >>> 2);
    endfunction

    function automatic t_bnd floor_q(input logic signed [A_W-1:0] a);
        return t_bnd'(a >>> 2);
    endfunction

    logic signed [A_W-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
    t_bnd xl, xh, yl, yh;

    always_comb begin
        x_lo_q = $signed(A_W'({i_req.center_x_half, 1'b0})) - $signed(A_W'(i_req.width_half));
        x_hi_q = $signed(A_W'({i_req.center_x_half, 1'b0})) + $signed(A_W'(i_req.width_half));
        y_lo_q = $signed(A_W'({i_req.center_y_half, 1'b0})) - $signed(A_W'(i_req.length_half));
        y_hi_q = $signed(A_W'({i_req.center_y_half, 1'b0})) + $signed(A_W'(i_req.length_half));
        xl = ceil_q(x_lo_q);
        xh = floor_q(x_hi_q);
        yl = ceil_q(y_lo_q);
        yh = floor_q(y_hi_q);
    end

    always_comb begin
        o_bnd.xl  = xl;
        o_bnd.xh  = xh;
        o_bnd.yl  = yl;
        o_bnd.yh  = yh;
        o_bnd.xlo = (xl < ZERO) ? ZERO : xl;
        o_bnd.xhi = (xh > COL_LIM) ? COL_LIM : xh;
        o_bnd.ylo = (yl < ZERO) ? ZERO : yl;
        o_bnd.yhi = (yh > ROW_LIM) ? ROW_LIM : yh;
        // Nothing to mark when the rectangle is inverted or lies wholly off the grid.
        o_bnd.empty = (xl > xh) || (yl > yh) || (xh < ZERO) || (xl > COL_LIM)
                      || (yh < ZERO) || (yl > ROW_LIM);
    end

endmodule

// File: rtl/core/greedy_grid_route_stepper.sv
// ----------------------------------------------------------------------------
// greedy_grid_route_stepper
// Greedy route planner over a grid of intersections with a memory cell map.
// ----------------------------------------------------------------------------
// Requests arrive on the i_req valid/ready channel and each one gives exactly
// one result on the o_res valid/ready channel. Start and goal are set through
// the plain write port i_cfg_*; the user writes them only while the block is idle, which the block does not enforce.
// One request is worked on at a time; the work from acceptance to a valid result:
//   clear map       every map cell in turn, one map cell written a cycle
//   add rectangle   a walk over the outline: each cell of the top and bottom rows
//                   and the first and last column of each other row
//   step            four neighbour reads through the single RAM read port
//                   plus the write-back of the current cell
//   at goal, unused no map access, straight to the result
// The cell map memory has a single write port and a single read port.
// After reset the map is cleared by a pass over every cell with o_req_ready
// low; configuration writes are taken during it.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted, but its result is held until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_grid_route_stepper #(
    parameter int GRID_COLS = ggrs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = ggrs_pkg::GRID_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  ggrs_pkg::t_req                     i_req,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output ggrs_pkg::t_res                     o_res,
    input  logic                               i_cfg_wr_en,
    input  logic [ggrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ggrs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import ggrs_pkg::*;

    localparam int CW     = $clog2(GRID_COLS + 1);
    localparam int RW     = $clog2(GRID_ROWS + 1);
    localparam int NCELLS = (GRID_COLS + 1) * (GRID_ROWS + 1);
    localparam int AW     = $clog2(NCELLS);
    localparam int DW     = COST_W - 1;

    localparam logic [CW-1:0] COL_MAX    = CW'(GRID_COLS);
    localparam logic [RW-1:0] ROW_MAX    = RW'(GRID_ROWS);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(GRID_COLS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_RECT  = 5'b00100,
        S_STEP  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [RW-1:0] y);
        return AW'(AW'(y) * ROW_STRIDE) + AW'(x);
    endfunction

    function automatic logic [CW-1:0] sat_x(input logic [POSX_W-1:0] v);
        return (DW'(v) > DW'(GRID_COLS)) ? COL_MAX : CW'(v);
    endfunction

    function automatic logic [RW-1:0] sat_y(input logic [POSY_W-1:0] v);
        return (DW'(v) > DW'(GRID_ROWS)) ? ROW_MAX : RW'(v);
    endfunction

    function automatic logic [COST_W-1:0] cell_cost(input logic [CELL_W-1:0] s,
                                                    input logic [CW-1:0]     x,
                                                    input logic [RW-1:0]     y,
                                                    input logic [POSX_W-1:0] gx,
                                                    input logic [POSY_W-1:0] gy);
        logic [DW-1:0] ex, ey, egx, egy, dx, dy;
        ex  = DW'(x);
        ey  = DW'(y);
        egx = DW'(gx);
        egy = DW'(gy);
        dx  = (egx > ex) ? (egx - ex) : (ex - egx);
        dy  = (egy > ey) ? (egy - ey) : (ey - egy);
        if (s == CELL_BLOCKED) begin
            return COST_BLOCKED;
        end else if (s == CELL_VISITED) begin
            return COST_VISITED;
        end
        return COST_W'(dx) + COST_W'(dy);
    endfunction

    // Configuration registers
    logic [POSX_W-1:0] r_start_x, r_goal_x;
    logic [POSY_W-1:0] r_start_y, r_goal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= START_X_RST;
            r_start_y <= START_Y_RST;
            r_goal_x  <= GOAL_X_RST;
            r_goal_y  <= GOAL_Y_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_START_X: r_start_x <= i_cfg_wdata[POSX_W-1:0];
                CFG_START_Y: r_start_y <= i_cfg_wdata[POSY_W-1:0];
                CFG_GOAL_X:  r_goal_x  <= i_cfg_wdata[POSX_W-1:0];
                CFG_GOAL_Y:  r_goal_y  <= i_cfg_wdata[POSY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control and payload registers
    t_state             r_state, n_state;
    logic [CW-1:0]      r_pos_x, n_pos_x, r_cur_x, n_cur_x, r_ev_x, n_ev_x;
    logic [RW-1:0]      r_pos_y, n_pos_y, r_cur_y, n_cur_y, r_ev_y, n_ev_y;
    logic [LDIR_W-1:0]  r_last_dir, n_last_dir, r_pick, n_pick, r_ev_dir, n_ev_dir;
    logic               r_resp_pend, n_resp_pend, r_ev_cons, n_ev_cons;
    logic [2:0]         r_cnt, n_cnt;
    logic [COST_W-1:0]  r_best, n_best;
    t_rect_bnd          r_bnd, n_bnd;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DIR_W-1:0]   r_dir, n_dir;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;

    // Map memory ports
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr, pos_addr, cur_addr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    t_rect_bnd         rect_bnd;

    ggrs_rect_bounds #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_rect_bounds (
        .i_req (i_req),
        .o_bnd (rect_bnd)
    );

    ggrs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Neighbour selected by the step counter: up, down, right, left.
    logic [CW-1:0]     nb_x;
    logic [RW-1:0]     nb_y;
    logic [LDIR_W-1:0] nb_dir;
    logic              nb_cons;

    always_comb begin
        nb_x    = r_pos_x;
        nb_y    = r_pos_y;
        nb_dir  = DIR_UP;
        nb_cons = 1'b0;
        case (r_cnt[1:0])
            2'd0: begin
                nb_y    = r_pos_y + RW'(1);
                nb_dir  = DIR_UP;
                nb_cons = (r_pos_y != ROW_MAX) && (r_last_dir != DIR_DOWN);
            end
            2'd1: begin
                nb_y    = r_pos_y - RW'(1);
                nb_dir  = DIR_DOWN;
                nb_cons = (r_pos_y != '0) && (r_last_dir != DIR_UP);
            end
            2'd2: begin
                nb_x    = r_pos_x + CW'(1);
                nb_dir  = DIR_RIGHT;
                nb_cons = (r_pos_x != COL_MAX) && (r_last_dir != DIR_LEFT);
            end
            2'd3: begin
                nb_x    = r_pos_x - CW'(1);
                nb_dir  = DIR_LEFT;
                nb_cons = (r_pos_x != '0) && (r_last_dir != DIR_RIGHT);
            end
            default: begin
            end
        endcase
    end

    // Evaluation of the neighbour whose cell state the RAM returns this cycle.
    logic [COST_W-1:0] ev_cost;
    logic              ev_take;
    logic [LDIR_W-1:0] fin_pick;

    always_comb begin
        ev_cost  = cell_cost(ram_rdata, r_ev_x, r_ev_y, r_goal_x, r_goal_y);
        ev_take  = r_ev_cons && (ev_cost < r_best);
        fin_pick = ev_take ? r_ev_dir : r_pick;
    end

    // Outline walker position relative to the rectangle edges.
    t_bnd cur_x_s, cur_y_s;
    logic rect_edge, at_goal, out_free, req_fire;
    logic clear_we, rect_we, step_we;

    always_comb begin
        cur_x_s   = t_bnd'(r_cur_x);
        cur_y_s   = t_bnd'(r_cur_y);
        rect_edge = (cur_y_s == r_bnd.yl) || (cur_y_s == r_bnd.yh);
        at_goal   = (DW'(r_pos_x) == DW'(r_goal_x)) && (DW'(r_pos_y) == DW'(r_goal_y));
        out_free  = !r_out_valid || i_res_ready;
        req_fire  = i_req_valid && o_req_ready;
    end

    always_comb begin
        pos_addr  = cell_addr(r_pos_x, r_pos_y);
        cur_addr  = cell_addr(r_cur_x, r_cur_y);
        clear_we  = (r_state == S_CLEAR);
        rect_we   = (r_state == S_RECT)
                    && (rect_edge || (cur_x_s == r_bnd.xl) || (cur_x_s == r_bnd.xh));
        step_we   = (r_state == S_STEP) && (r_cnt == 3'd4);
        ram_we    = clear_we || rect_we || step_we;
        ram_waddr = step_we ? pos_addr : cur_addr;
        if (step_we) begin
            ram_wdata = CELL_VISITED;
        end else if (rect_we || (r_cur_x == '0) || (r_cur_y == '0)
                     || (r_cur_x == COL_MAX) || (r_cur_y == ROW_MAX)) begin
            ram_wdata = CELL_BLOCKED;
        end else begin
            ram_wdata = CELL_FREE;
        end
        ram_re    = (r_state == S_STEP) && !r_cnt[2] && nb_cons;
        ram_raddr = cell_addr(nb_x, nb_y);
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state     = r_state;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_last_dir  = r_last_dir;
        n_resp_pend = r_resp_pend;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_pick      = r_pick;
        n_ev_cons   = r_ev_cons;
        n_ev_x      = r_ev_x;
        n_ev_y      = r_ev_y;
        n_ev_dir    = r_ev_dir;
        n_bnd       = r_bnd;
        n_status    = r_status;
        n_dir       = r_dir;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_status = ST_DONE;
                    n_dir    = DIR_UP[DIR_W-1:0];
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_pos_x     = sat_x(r_start_x);
                            n_pos_y     = sat_y(r_start_y);
                            n_last_dir  = DIR_NONE;
                            n_cur_x     = '0;
                            n_cur_y     = '0;
                            n_resp_pend = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        REQ_ADD: begin
                            n_bnd = rect_bnd;
                            if (rect_bnd.empty) begin
                                n_state = S_RESP;
                            end else begin
                                n_cur_x = CW'(rect_bnd.xlo);
                                n_cur_y = RW'(rect_bnd.ylo);
                                n_state = S_RECT;
                            end
                        end
                        REQ_STEP: begin
                            if (at_goal) begin
                                n_status = ST_GOAL;
                                n_state  = S_RESP;
                            end else begin
                                n_cnt     = '0;
                                n_best    = COST_BLOCKED;
                                n_pick    = DIR_NONE;
                                n_ev_cons = 1'b0;
                                n_state   = S_STEP;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                if (r_cur_x == COL_MAX) begin
                    n_cur_x = '0;
                    if (r_cur_y == ROW_MAX) begin
                        n_resp_pend = 1'b0;
                        n_state     = r_resp_pend ? S_RESP : S_IDLE;
                    end else begin
                        n_cur_y = r_cur_y + RW'(1);
                    end
                end else begin
                    n_cur_x = r_cur_x + CW'(1);
                end
            end

            S_RECT: begin
                // Top and bottom rows are walked cell by cell; other rows only
                // touch the first and last columns.
                if (r_cur_x == CW'(r_bnd.xhi)) begin
                    if (r_cur_y == RW'(r_bnd.yhi)) begin
                        n_state = S_RESP;
                    end else begin
                        n_cur_y = r_cur_y + RW'(1);
                        n_cur_x = CW'(r_bnd.xlo);
                    end
                end else if (rect_edge) begin
                    n_cur_x = r_cur_x + CW'(1);
                end else begin
                    n_cur_x = CW'(r_bnd.xhi);
                end
            end

            S_STEP: begin
                // Read of neighbour k overlaps the evaluation of neighbour k-1.
                if (ev_take) begin
                    n_best = ev_cost;
                    n_pick = r_ev_dir;
                end
                if (!r_cnt[2]) begin
                    n_ev_cons = nb_cons;
                    n_ev_x    = nb_x;
                    n_ev_y    = nb_y;
                    n_ev_dir  = nb_dir;
                    n_cnt     = r_cnt + 3'd1;
                end else begin
                    n_state = S_RESP;
                    if (fin_pick == DIR_NONE) begin
                        n_status = ST_STUCK;
                    end else begin
                        n_status   = ST_MOVED;
                        n_dir      = fin_pick[DIR_W-1:0];
                        n_last_dir = fin_pick;
                        case (fin_pick)
                            DIR_UP:    n_pos_y = r_pos_y + RW'(1);
                            DIR_DOWN:  n_pos_y = r_pos_y - RW'(1);
                            DIR_RIGHT: n_pos_x = r_pos_x + CW'(1);
                            default:   n_pos_x = r_pos_x - CW'(1);
                        endcase
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.direction = r_dir;
                    n_out.pos_x     = POSX_W'(r_pos_x);
                    n_out.pos_y     = POSY_W'(r_pos_y);
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos_x     <= sat_x(START_X_RST);
            r_pos_y     <= sat_y(START_Y_RST);
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_last_dir  <= DIR_NONE;
            r_resp_pend <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_last_dir  <= n_last_dir;
            r_resp_pend <= n_resp_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_pick    <= n_pick;
        r_ev_cons <= n_ev_cons;
        r_ev_x    <= n_ev_x;
        r_ev_y    <= n_ev_y;
        r_ev_dir  <= n_ev_dir;
        r_bnd     <= n_bnd;
        r_status  <= n_status;
        r_dir     <= n_dir;
        r_out     <= n_out;
    end

    `GGRS_ASSERT(a_pos_in_grid, (r_pos_x <= COL_MAX) && (r_pos_y <= ROW_MAX), "position off grid")
    `GGRS_ASSERT(a_one_writer, $onehot0({clear_we, rect_we, step_we}), "two map writers at once")
    `GGRS_ASSERT_IF(a_no_self_read, ram_re, ram_raddr != pos_addr, "step read its own cell")
    `GGRS_ASSERT_IF(a_resp_loads, (r_state == S_RESP) && out_free, ##1 o_res_valid, "result lost")

endmodule
